[hdl/tspa_pkg.sv]
package tspa_pkg;

  // Default table dimensions.
  localparam int SLOTS_DEF      = 64;
  localparam int CATEGORIES_DEF = 2;

  // Field widths.
  localparam int POS_W    = 16;
  localparam int COORD_W  = 12;
  localparam int SLOT_W   = 6;
  localparam int VOL_W    = 7;
  localparam int SUM_W    = 32;
  localparam int DIST_W   = 17;
  localparam int NUM_W    = 19;
  localparam int QUOT_W   = 7;

  // The slot and category fields limit how many table entries can be reached.
  localparam int SLOT_FIELD_MAX = 64;
  localparam int CAT_FIELD_MAX  = 2;

  // Depth of the queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

  // Reset values of the configuration registers and the full volume.
  localparam logic [COORD_W-1:0] LEFT_CENTRE_RST  = 12'd200;
  localparam logic [COORD_W-1:0] RIGHT_CENTRE_RST = 12'd600;
  localparam logic [COORD_W-1:0] NEAR_RADIUS_RST  = 12'd200;
  localparam logic [COORD_W-1:0] FAR_RADIUS_RST   = 12'd400;
  localparam logic [VOL_W-1:0]   VOL_FULL         = 7'd100;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CENTRE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CENTRE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_RADIUS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_RADIUS   = 2'd3;

  // Input item.
  typedef struct packed {
    logic                    cmd;
    logic                    category;
    logic [SLOT_W-1:0]       slot;
    logic signed [POS_W-1:0] world_x;
    logic signed [POS_W-1:0] camera_x;
  } item_t;

  // Result item.
  typedef struct packed {
    logic [VOL_W-1:0] left_volume;
    logic [VOL_W-1:0] right_volume;
    logic [SUM_W-1:0] left_total;
    logic [SUM_W-1:0] right_total;
    logic             silent;
  } result_t;

  // Configuration registers.
  typedef struct packed {
    logic [COORD_W-1:0] left_centre;
    logic [COORD_W-1:0] right_centre;
    logic [COORD_W-1:0] near_radius;
    logic [COORD_W-1:0] far_radius;
  } cfg_t;

  // Classified ear: either a fixed volume or a division still to do.
  typedef struct packed {
    logic               div;
    logic [VOL_W-1:0]   vol;
    logic [NUM_W-1:0]   num;
    logic [COORD_W-1:0] den;
  } ear_t;

  // Queue entry handed from the front end to the back end.
  typedef struct packed {
    logic              frame;
    logic              in_range;
    logic              category;
    logic [SLOT_W-1:0] slot;
    ear_t              ear_l;
    ear_t              ear_r;
  } entry_t;

  // Queue status.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_IDLE,
    BK_CALC
  } back_state_e;

endpackage

[hdl/tspa_fifo.sv]
module tspa_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tspa_pkg::entry_t    entry_i,
  input  logic                pop_i,
  output tspa_pkg::q_status_t stat_o,
  output tspa_pkg::entry_t    entry_o
);

  localparam int Depth = tspa_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  tspa_pkg::entry_t entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    if (p == PtrW'(Depth - 1)) begin
      return '0;
    end
    return p + PtrW'(1);
  endfunction

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

  // Status and head of the queue.
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign entry_o      = entries_q[rd_ptr_q];

endmodule

[hdl/tspa_front.sv]
module tspa_front #(
  parameter int SLOTS      = tspa_pkg::SLOTS_DEF,
  parameter int CATEGORIES = tspa_pkg::CATEGORIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  tspa_pkg::item_t                     item_i,
  input  logic                                cfg_we_i,
  input  logic [tspa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tspa_pkg::COORD_W-1:0]        cfg_data_i,
  input  tspa_pkg::q_status_t                 q_stat_i,
  output logic                                push_o,
  output tspa_pkg::entry_t                    entry_o
);

  localparam int DistW  = tspa_pkg::DIST_W;
  localparam int CoordW = tspa_pkg::COORD_W;
  localparam int NumW   = tspa_pkg::NUM_W;

  // Second stage holds the two ear distances.
  typedef struct packed {
    logic                        frame;
    logic                        in_range;
    logic                        category;
    logic [tspa_pkg::SLOT_W-1:0] slot;
    logic [DistW-1:0]            dist_l;
    logic [DistW-1:0]            dist_r;
  } stage2_t;

  tspa_pkg::cfg_t  cfg_q;
  logic            s1_valid_q, s1_valid_d;
  tspa_pkg::item_t s1_item_q;
  logic            s2_valid_q, s2_valid_d;
  stage2_t         s2_q, s2_d;
  logic            accept;
  logic            s1_adv;
  logic            s2_free;
  logic [DistW-1:0] screen_x;

  // Distance of the screen position from one speaker.
  function automatic logic [DistW-1:0] ear_dist(input logic [DistW-1:0] sx,
                                                input logic [CoordW-1:0] centre);
    logic [DistW:0] diff;
    logic [DistW:0] mag;
    diff = {sx[DistW-1], sx} - (DistW + 1)'(centre);
    mag  = diff[DistW] ? (DistW + 1)'(-diff) : diff;
    return mag[DistW-1:0];
  endfunction

  // Sort one ear into full, zero or a falloff that needs a division.
  function automatic tspa_pkg::ear_t ear_class(input logic [DistW-1:0] d,
                                               input logic [CoordW-1:0] near_r,
                                               input logic [CoordW-1:0] far_r,
                                               input logic frame);
    tspa_pkg::ear_t e;
    logic [CoordW-1:0] gap;
    gap   = far_r - d[CoordW-1:0];
    e.div = 1'b0;
    e.vol = '0;
    e.num = NumW'(gap) * NumW'(tspa_pkg::VOL_FULL);
    e.den = far_r - near_r;
    if (frame) begin
      e.vol = '0;
    end else if (d < DistW'(near_r)) begin
      e.vol = tspa_pkg::VOL_FULL;
    end else if (d >= DistW'(far_r)) begin
      e.vol = '0;
    end else begin
      e.div = 1'b1;
    end
    return e;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_centre  <= tspa_pkg::LEFT_CENTRE_RST;
      cfg_q.right_centre <= tspa_pkg::RIGHT_CENTRE_RST;
      cfg_q.near_radius  <= tspa_pkg::NEAR_RADIUS_RST;
      cfg_q.far_radius   <= tspa_pkg::FAR_RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tspa_pkg::CFG_LEFT_CENTRE:  cfg_q.left_centre  <= cfg_data_i;
        tspa_pkg::CFG_RIGHT_CENTRE: cfg_q.right_centre <= cfg_data_i;
        tspa_pkg::CFG_NEAR_RADIUS:  cfg_q.near_radius  <= cfg_data_i;
        tspa_pkg::CFG_FAR_RADIUS:   cfg_q.far_radius   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage flow: an item moves on when the next stage is free or moving too.
  always_comb begin
    push_o     = s2_valid_q && !q_stat_i.full;
    s2_free    = !s2_valid_q || push_o;
    s1_adv     = s1_valid_q && s2_free;
    busy       = s1_valid_q && !s1_adv;
    accept     = start && !busy;
    s1_valid_d = accept || (s1_valid_q && !s1_adv);
    s2_valid_d = s1_adv || (s2_valid_q && !push_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // First stage captures the accepted item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_i;
    end
  end

  // Screen position, ear distances and the table range check.
  always_comb begin
    screen_x = {s1_item_q.world_x[tspa_pkg::POS_W-1], s1_item_q.world_x}
             - {s1_item_q.camera_x[tspa_pkg::POS_W-1], s1_item_q.camera_x};
    s2_d.frame    = s1_item_q.cmd;
    s2_d.in_range = (int'(s1_item_q.category) < CATEGORIES) && (int'(s1_item_q.slot) < SLOTS);
    s2_d.category = s1_item_q.category;
    s2_d.slot     = s1_item_q.slot;
    s2_d.dist_l   = ear_dist(screen_x, cfg_q.left_centre);
    s2_d.dist_r   = ear_dist(screen_x, cfg_q.right_centre);
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_q <= s2_d;
    end
  end

  // Second stage classifies both ears into a queue entry.
  always_comb begin
    entry_o.frame    = s2_q.frame;
    entry_o.in_range = s2_q.in_range;
    entry_o.category = s2_q.category;
    entry_o.slot     = s2_q.slot;
    entry_o.ear_l    = ear_class(s2_q.dist_l, cfg_q.near_radius, cfg_q.far_radius, s2_q.frame);
    entry_o.ear_r    = ear_class(s2_q.dist_r, cfg_q.near_radius, cfg_q.far_radius, s2_q.frame);
  end

endmodule

[hdl/tspa_div.sv]
module tspa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tspa_pkg::NUM_W-1:0]   num_i,
  input  logic [tspa_pkg::COORD_W-1:0] den_i,
  output logic                         busy_o,
  output logic [tspa_pkg::QUOT_W-1:0]  quot_o
);

  localparam int QuotW  = tspa_pkg::QUOT_W;
  localparam int CoordW = tspa_pkg::COORD_W;
  localparam int CntW   = $clog2(QuotW + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CoordW-1:0] rem_q, rem_d;
  logic [QuotW-1:0]  low_q, low_d;
  logic [QuotW-1:0]  quot_q, quot_d;
  logic [CoordW-1:0] den_q;
  logic [CoordW:0]   trial;
  logic              fits;

  // One restoring step a cycle: shift in the next numerator bit, subtract if it fits.
  always_comb begin
    trial  = {rem_q, low_q[QuotW-1]};
    fits   = (trial >= {1'b0, den_q});
    rem_d  = fits ? CoordW'(trial - {1'b0, den_q}) : trial[CoordW-1:0];
    low_d  = {low_q[QuotW-2:0], 1'b0};
    quot_d = {quot_q[QuotW-2:0], fits};
    cnt_d  = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(QuotW);
    end else if (busy_o) begin
      cnt_q <= cnt_d;
    end
  end

  // The quotient is below 128, so the top numerator bits start below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i[tspa_pkg::NUM_W-1:QuotW];
      low_q  <= num_i[QuotW-1:0];
      quot_q <= '0;
      den_q  <= den_i;
    end else if (busy_o) begin
      rem_q  <= rem_d;
      low_q  <= low_d;
      quot_q <= quot_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;

endmodule

[hdl/tspa_back.sv]
module tspa_back #(
  parameter int SLOTS      = tspa_pkg::SLOTS_DEF,
  parameter int CATEGORIES = tspa_pkg::CATEGORIES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tspa_pkg::entry_t    entry_i,
  input  tspa_pkg::q_status_t q_stat_i,
  output logic                pop_o,
  output tspa_pkg::result_t   result_o,
  output logic                result_valid_o
);

  localparam int SlotUsed = (SLOTS < tspa_pkg::SLOT_FIELD_MAX) ? SLOTS : tspa_pkg::SLOT_FIELD_MAX;
  localparam int CatUsed  = (CATEGORIES < tspa_pkg::CAT_FIELD_MAX) ?
                            CATEGORIES : tspa_pkg::CAT_FIELD_MAX;
  localparam int Depth    = SlotUsed * CatUsed;
  localparam int IdxW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SumW     = tspa_pkg::SUM_W;
  localparam int VolW     = tspa_pkg::VOL_W;

  tspa_pkg::back_state_e state_q, state_d;
  tspa_pkg::entry_t      cur_q;
  tspa_pkg::result_t     result_q, result_d;
  logic                  valid_q;
  logic [Depth-1:0]      seen_q;
  logic [2*SumW-1:0]     sum_mem [Depth];
  logic [2*SumW-1:0]     sum_rd_q;
  logic [IdxW-1:0]       head_idx;
  logic [IdxW-1:0]       cur_idx;
  logic                  busy_l, busy_r;
  logic [VolW-1:0]       quot_l, quot_r;
  logic                  emit;
  logic                  mem_we;
  logic [VolW-1:0]       vol_l, vol_r;
  logic [SumW-1:0]       base_l, base_r;
  logic [SumW-1:0]       total_l, total_r;

  // Table entry of the queue head and of the item at work.
  assign head_idx = IdxW'(int'(entry_i.category) * SlotUsed + int'(entry_i.slot));
  assign cur_idx  = IdxW'(int'(cur_q.category) * SlotUsed + int'(cur_q.slot));

  // Serial dividers for the two ears, started as the item leaves the queue.
  tspa_div u_div_l (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pop_o && entry_i.ear_l.div),
    .num_i   (entry_i.ear_l.num),
    .den_i   (entry_i.ear_l.den),
    .busy_o  (busy_l),
    .quot_o  (quot_l)
  );

  tspa_div u_div_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pop_o && entry_i.ear_r.div),
    .num_i   (entry_i.ear_r.num),
    .den_i   (entry_i.ear_r.den),
    .busy_o  (busy_r),
    .quot_o  (quot_r)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tspa_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = tspa_pkg::BK_CALC;
        end
      end
      tspa_pkg::BK_CALC: begin
        if (!busy_l && !busy_r) begin
          state_d = tspa_pkg::BK_IDLE;
        end
      end
      default: state_d = tspa_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop_o = 1'b0;
    emit  = 1'b0;
    case (state_q)
      tspa_pkg::BK_IDLE: pop_o = !q_stat_i.empty;
      tspa_pkg::BK_CALC: emit  = !busy_l && !busy_r;
      default: ;
    endcase
  end

  // Volumes, slot sums and the result item.
  always_comb begin
    vol_l   = cur_q.ear_l.div ? quot_l : cur_q.ear_l.vol;
    vol_r   = cur_q.ear_r.div ? quot_r : cur_q.ear_r.vol;
    base_l  = seen_q[cur_idx] ? sum_rd_q[2*SumW-1:SumW] : '0;
    base_r  = seen_q[cur_idx] ? sum_rd_q[SumW-1:0] : '0;
    total_l = base_l + SumW'(vol_l);
    total_r = base_r + SumW'(vol_r);
    mem_we  = emit && !cur_q.frame && cur_q.in_range;

    result_d.left_volume  = vol_l;
    result_d.right_volume = vol_r;
    result_d.left_total   = cur_q.in_range ? total_l : '0;
    result_d.right_total  = cur_q.in_range ? total_r : '0;
    result_d.silent       = (vol_l == '0) && (vol_r == '0);
    if (cur_q.frame) begin
      result_d = '0;
    end
  end

  // Control registers and seen flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tspa_pkg::BK_IDLE;
      valid_q <= 1'b0;
      seen_q  <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= emit;
      if (emit && cur_q.frame) begin
        seen_q <= '0;
      end else if (mem_we) begin
        seen_q[cur_idx] <= 1'b1;
      end
    end
  end

  // Item at work and the result register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
    if (emit) begin
      result_q <= result_d;
    end
  end

  // Slot sums memory: left sum in the upper half, right sum in the lower.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sum_rd_q <= sum_mem[head_idx];
    end
    if (mem_we) begin
      sum_mem[cur_idx] <= {total_l, total_r};
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

[hdl/two_speaker_pan_accumulator.sv]
// Channel   Direction  Ports                                    Handshake
// command   in         start, busy, item_i                      taken when start and not busy
// config    in         cfg_we_i, cfg_idx_i, cfg_data_i          written when cfg_we_i is high
// result    out        result_valid_o, result_o                 one cycle, cannot be held off
//
// A pan item that needs a division in either ear occupies the back end until the
// seven-step serial dividers finish; other items leave the back end without a division.
// From acceptance an item passes the two front stages and the queue before the
// back end reports its result.
// Two front stages and a two-entry queue let new items be taken while the back end works.
// Reset clears all seen flags at once; there is no clearing pass.
// The receiver cannot stall: every result shows for exactly one cycle.
module two_speaker_pan_accumulator #(
  parameter int SLOTS      = tspa_pkg::SLOTS_DEF,
  parameter int CATEGORIES = tspa_pkg::CATEGORIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  tspa_pkg::item_t                item_i,
  input  logic                           cfg_we_i,
  input  logic [tspa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tspa_pkg::COORD_W-1:0]   cfg_data_i,
  output tspa_pkg::result_t              result_o,
  output logic                           result_valid_o
);

  tspa_pkg::q_status_t q_stat;
  tspa_pkg::entry_t    push_entry;
  tspa_pkg::entry_t    head_entry;
  logic                push;
  logic                pop;

  // Front end: accepts, measures and classifies items.
  tspa_front #(
    .SLOTS      (SLOTS),
    .CATEGORIES (CATEGORIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue between the two ends.
  tspa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .stat_o  (q_stat),
    .entry_o (head_entry)
  );

  // Back end: divides, accumulates and reports.
  tspa_back #(
    .SLOTS      (SLOTS),
    .CATEGORIES (CATEGORIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (head_entry),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

`ifndef SYNTHESIS
  // The back end returns to idle after each result, so results never come back to back.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two results in consecutive cycles");

  // The back end only takes an item the queue holds.
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // Result volumes never exceed full volume.
  a_volume_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.left_volume <= tspa_pkg::VOL_FULL) &&
                       (result_o.right_volume <= tspa_pkg::VOL_FULL))
    else $error("volume above full scale");

  // A heard source is never flagged silent.
  a_silent_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && ((result_o.left_volume != '0) || (result_o.right_volume != '0))
      |-> !result_o.silent)
    else $error("silent flag set with nonzero volume");
`endif

endmodule

[dv/pan_checker.sv]
`timescale 1ns / 100ps

// Watches the command, configuration and result channels of the pan block.
// It keeps its own copy of the registers and the per-slot tables, works out
// the result of every accepted item, and compares each result strobe with
// the oldest outstanding prediction.
module pan_checker
  import tspa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 busy,
  input  item_t                item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  result_t              result_o,
  input  logic                 result_valid_o,
  output int                   due_count_o,
  output int                   fail_count_o
);

  localparam int ENTRIES = SLOTS_DEF * CATEGORIES_DEF;

  // Shadow registers and table state.
  cfg_t             regs;
  logic             seen [ENTRIES];
  logic [SUM_W-1:0] left_sum [ENTRIES];
  logic [SUM_W-1:0] right_sum [ENTRIES];
  result_t          pan_results_due [$];
  int               mismatches;

  // Linear falloff of one ear around its speaker.
  function automatic logic [VOL_W-1:0] ear_gain(input int screen_x,
                                                input logic [COORD_W-1:0] centre);
    int sep;
    sep = screen_x - int'(centre);
    if (sep < 0) sep = -sep;
    if (sep < int'(regs.near_radius)) return VOL_FULL;
    if (sep >= int'(regs.far_radius)) return '0;
    return VOL_W'((int'(regs.far_radius) - sep) * int'(VOL_FULL)
                  / (int'(regs.far_radius) - int'(regs.near_radius)));
  endfunction

  // Applies one item to the tables and returns the result it must produce.
  function automatic result_t pan_predict(input item_t it);
    result_t res;
    int      screen_x;
    int      idx;
    res = '0;
    if (it.cmd) begin
      for (int k = 0; k < ENTRIES; k++) seen[k] = 1'b0;
      return res;
    end
    screen_x = int'($signed(it.world_x)) - int'($signed(it.camera_x));
    res.left_volume  = ear_gain(screen_x, regs.left_centre);
    res.right_volume = ear_gain(screen_x, regs.right_centre);
    res.silent       = (res.left_volume == 0) && (res.right_volume == 0);
    if (int'(it.category) < CATEGORIES_DEF && int'(it.slot) < SLOTS_DEF) begin
      idx = int'(it.category) * SLOTS_DEF + int'(it.slot);
      // The first pan of a slot in a frame starts its sums from zero.
      if (!seen[idx]) begin
        left_sum[idx]  = '0;
        right_sum[idx] = '0;
      end
      left_sum[idx]    = left_sum[idx] + SUM_W'(res.left_volume);
      right_sum[idx]   = right_sum[idx] + SUM_W'(res.right_volume);
      seen[idx]        = 1'b1;
      res.left_total   = left_sum[idx];
      res.right_total  = right_sum[idx];
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      regs = '{left_centre: LEFT_CENTRE_RST, right_centre: RIGHT_CENTRE_RST,
               near_radius: NEAR_RADIUS_RST, far_radius: FAR_RADIUS_RST};
      for (int k = 0; k < ENTRIES; k++) begin
        seen[k]      = 1'b0;
        left_sum[k]  = '0;
        right_sum[k] = '0;
      end
      pan_results_due.delete();
      mismatches   = 0;
      due_count_o  <= 0;
      fail_count_o <= 0;
    end else begin
      // Register writes take effect for items accepted afterwards.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LEFT_CENTRE:  regs.left_centre  = cfg_data_i;
          CFG_RIGHT_CENTRE: regs.right_centre = cfg_data_i;
          CFG_NEAR_RADIUS:  regs.near_radius  = cfg_data_i;
          CFG_FAR_RADIUS:   regs.far_radius   = cfg_data_i;
          default: ;
        endcase
      end
      // Compare a result strobe with the oldest prediction.
      if (result_valid_o) begin
        if (pan_results_due.size() == 0) begin
          $display("%0t: no item outstanding, got result %p", $time, result_o);
          mismatches++;
        end else begin
          want = pan_results_due.pop_front();
          check_field("left_volume", SUM_W'(want.left_volume),
                      SUM_W'(result_o.left_volume));
          check_field("right_volume", SUM_W'(want.right_volume),
                      SUM_W'(result_o.right_volume));
          check_field("left_total", want.left_total, result_o.left_total);
          check_field("right_total", want.right_total, result_o.right_total);
          check_field("silent", SUM_W'(want.silent), SUM_W'(result_o.silent));
        end
      end
      // Predict every accepted item.
      if (start && !busy) pan_results_due.push_back(pan_predict(item_i));
      due_count_o  <= pan_results_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

// Drives the pan block through a directed opening and eight register
// settings of random items, with random gaps before the first 1200 items.
module tb_top;
  import tspa_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int PHASES          = 8;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  item_t                item_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COORD_W-1:0]   cfg_data_i;
  result_t              result_o;
  logic                 result_valid_o;
  int                   due_count;
  int                   fail_count;
  int                   cycle_count;
  int                   items_sent;
  cfg_t                 cur_cfg;

  two_speaker_pan_accumulator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  pan_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o),
    .due_count_o    (due_count),
    .fail_count_o   (fail_count)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic item_t mk_item(input logic cmd, input logic cat, input int slot,
                                    input int wx, input int cx);
    item_t it;
    it.cmd      = cmd;
    it.category = cat;
    it.slot     = SLOT_W'(slot);
    it.world_x  = POS_W'(wx);
    it.camera_x = POS_W'(cx);
    return it;
  endfunction

  function automatic item_t random_item();
    return mk_item(1'($urandom), 1'($urandom), $urandom_range(63), $urandom, $urandom);
  endfunction

  // Offers one item, maybe after a random gap, and returns once it is taken.
  // Start stays high afterwards so back-to-back items need no extra edge.
  task automatic offer_item(input item_t it);
    int idle_pct;
    idle_pct = (items_sent < 600) ? 35 : (items_sent < 1200) ? 47 : 0;
    if ($urandom_range(99) < idle_pct) begin
      start  <= 1'b0;
      item_i <= random_item();
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  // Lets every outstanding item come back before the registers change.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (due_count != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_t c);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [COORD_W-1:0]   val [4];
    idx = '{CFG_LEFT_CENTRE, CFG_RIGHT_CENTRE, CFG_NEAR_RADIUS, CFG_FAR_RADIUS};
    val = '{c.left_centre, c.right_centre, c.near_radius, c.far_radius};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= val[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_cfg = c;
  endtask

  // Register settings per phase: extremes, near not below far, and random.
  function automatic cfg_t phase_cfg(input int p);
    cfg_t c;
    int   far_r;
    case (p)
      1:       c = '{12'd0, 12'd4095, 12'd0, 12'd4095};
      2:       c = '{12'd4095, 12'd0, 12'd4095, 12'd0};
      3:       c = '{12'd2048, 12'd2048, 12'd300, 12'd300};
      4:       c = '{LEFT_CENTRE_RST, RIGHT_CENTRE_RST, NEAR_RADIUS_RST, FAR_RADIUS_RST};
      5:       c = '{12'd100, 12'd3995, 12'd0, 12'd1};
      6: begin
        c = '{COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom)};
      end
      default: begin
        far_r = $urandom_range(4095);
        c = '{COORD_W'($urandom_range(4095)), COORD_W'($urandom_range(4095)),
              COORD_W'($urandom_range(far_r)), COORD_W'(far_r)};
      end
    endcase
    return c;
  endfunction

  initial begin
    item_t it;
    int    r;
    int    centre;
    int    off;
    int    reach;
    int    cam;
    rst_ni     = 1'b0;
    start      = 1'b0;
    item_i     = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    items_sent = 0;
    cur_cfg    = '{LEFT_CENTRE_RST, RIGHT_CENTRE_RST, NEAR_RADIUS_RST, FAR_RADIUS_RST};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening under the reset settings: the edges of both falloff
    // zones, accumulation into one slot, frame items, and extreme positions.
    offer_item(mk_item(1'b0, 1'b0, 0, 200, 0));
    offer_item(mk_item(1'b0, 1'b0, 0, 399, 0));
    offer_item(mk_item(1'b0, 1'b0, 0, 400, 0));
    offer_item(mk_item(1'b0, 1'b0, 0, 600, 0));
    offer_item(mk_item(1'b0, 1'b0, 0, 599, 0));
    offer_item(mk_item(1'b0, 1'b0, 0, 401, 1));
    offer_item(mk_item(1'b0, 1'b0, 1, 32767, -32768));
    offer_item(mk_item(1'b0, 1'b0, 1, -32768, 32767));
    offer_item(mk_item(1'b0, 1'b1, 2, -32768, -32768));
    offer_item(mk_item(1'b0, 1'b1, 2, 32767, 32767));
    offer_item(mk_item(1'b0, 1'b1, 63, 1000, 0));
    offer_item(mk_item(1'b0, 1'b1, 63, -200, 0));
    offer_item(mk_item(1'b0, 1'b1, 63, 1, 0));
    offer_item(mk_item(1'b1, 1'b0, 0, 0, 0));
    offer_item(mk_item(1'b0, 1'b0, 0, 200, 0));
    offer_item(mk_item(1'b0, 1'b1, 63, 800, 200));
    offer_item(mk_item(1'b1, 1'b1, 63, -1, -1));
    offer_item(mk_item(1'b0, 1'b1, 63, 0, 0));
    offer_item(mk_item(1'b0, 1'b1, 63, 0, 0));
    offer_item(mk_item(1'b0, 1'b0, 42, -1, 32767));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        write_cfg(phase_cfg(p));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(99);
        if (r < 6) begin
          // Frame item with noise in the ignored fields.
          it     = random_item();
          it.cmd = 1'b1;
        end else if (r < 22) begin
          // Any position at all.
          it     = random_item();
          it.cmd = 1'b0;
        end else begin
          // A source near one of the speakers, mostly into a few hot slots
          // so the sums build up within a frame.
          it          = random_item();
          it.cmd      = 1'b0;
          if ($urandom_range(99) < 75) it.slot = SLOT_W'($urandom_range(5));
          else if ($urandom_range(1)) it.slot = SLOT_W'(63);
          centre = $urandom_range(1) ? int'(cur_cfg.left_centre)
                                     : int'(cur_cfg.right_centre);
          reach  = (cur_cfg.far_radius > cur_cfg.near_radius) ?
                   int'(cur_cfg.far_radius) : int'(cur_cfg.near_radius);
          case ($urandom_range(3))
            0:       off = int'(cur_cfg.near_radius) - $urandom_range(1);
            1:       off = int'(cur_cfg.far_radius) - $urandom_range(1);
            default: off = $urandom_range(reach + 40);
          endcase
          if ($urandom_range(1)) off = -off;
          cam         = $urandom_range(40000) - 20000;
          it.camera_x = POS_W'(cam);
          it.world_x  = POS_W'(cam + centre + off);
        end
        offer_item(it);
      end
    end

    // Drain and allow for any stray late result.
    start <= 1'b0;
    do @(posedge clk_i); while (due_count != 0);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/tspa_pkg.sv
hdl/tspa_fifo.sv
hdl/tspa_front.sv
hdl/tspa_div.sv
hdl/tspa_back.sv
hdl/two_speaker_pan_accumulator.sv
dv/pan_checker.sv
dv/tb_top.sv
